// File: rtl/dmm_pkg.sv
// Package with the shared types, codes and defaults of the display mode matcher.
`timescale 1ns / 1ps

package dmm_pkg;

  localparam int DMM_MAX_MODES    = 64;
  localparam int DMM_MAX_DISPLAYS = 4;

  localparam int DMM_DISP_W = 2;
  localparam int DMM_DIM_W  = 12;
  localparam int DMM_SQ_W   = 2 * DMM_DIM_W;
  localparam int DMM_DIST_W = DMM_SQ_W + 1;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_MATCH   = 2'd2,
    KIND_DEFAULT = 2'd3
  } dmm_kind_t;

  localparam logic [2:0] OUTC_EXACT   = 3'd0;
  localparam logic [2:0] OUTC_TALLER  = 3'd1;
  localparam logic [2:0] OUTC_SHORTER = 3'd2;
  localparam logic [2:0] OUTC_NEAREST = 3'd3;
  localparam logic [2:0] OUTC_DEFAULT = 3'd4;
  localparam logic [2:0] OUTC_NONE    = 3'd5;

  typedef struct packed {
    dmm_kind_t               kind;
    logic [DMM_DISP_W-1:0]   display;
    logic [DMM_DIM_W-1:0]    width;
    logic [DMM_DIM_W-1:0]    height;
    logic                    is_default;
  } dmm_in_req_t;

  typedef struct packed {
    logic [DMM_DIM_W-1:0] out_width;
    logic [DMM_DIM_W-1:0] out_height;
    logic [2:0]           outcome;
  } dmm_out_rsp_t;

  typedef struct packed {
    logic [DMM_DISP_W-1:0] display;
    logic [DMM_DIM_W-1:0]  width;
    logic [DMM_DIM_W-1:0]  height;
    logic                  is_default;
  } dmm_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;   // store the incoming load request if it fits
    logic clear;   // empty the table
    logic start;   // latch the query and reset the running bests
    logic issue;   // read the entry at the scan index and advance it
    logic finish;  // move the decided result into the output register
  } dmm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // no entry stored
    logic last;      // scan index points at the last stored entry
    logic busy;      // compare pipeline still holds an entry
    logic out_free;  // output register can take a result this cycle
  } dmm_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } dmm_state_t;

endpackage

// File: rtl/dmm_ctrl.sv
// Controller state machine that sequences loads, clears and table scans.
`timescale 1ns / 1ps

module dmm_ctrl
  import dmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  dmm_kind_t in_kind,
  output logic      in_stall,
  input  dmm_stat_t stat,
  output dmm_cmd_t  cmd
);

  dmm_state_t state_r;
  dmm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_kind)
            KIND_LOAD: begin
              cmd.write = 1'b1;
            end
            KIND_CLEAR: begin
              cmd.clear = 1'b1;
            end
            KIND_MATCH, KIND_DEFAULT: begin
              cmd.start = 1'b1;
              state_nxt = stat.empty ? ST_FIN : ST_SCAN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/dmm_datapath.sv
// Datapath with the mode memory, the compare pipeline and the output register.
`timescale 1ns / 1ps

module dmm_datapath
  import dmm_pkg::*;
#(
  parameter int MAX_MODES    = DMM_MAX_MODES,
  parameter int MAX_DISPLAYS = DMM_MAX_DISPLAYS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  dmm_cmd_t     cmd,
  output dmm_stat_t    stat,
  input  dmm_in_req_t  in_req,
  output logic         out_valid,
  input  logic         out_stall,
  output dmm_out_rsp_t out_rsp
);

  localparam int CNT_W  = $clog2(MAX_MODES + 1);
  localparam int IDX_W  = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int DCMP_W = 5;

  dmm_entry_t mode_mem_r [MAX_MODES];

  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;

  // Latched query.
  logic                 q_dflt_r;
  logic [DMM_DISP_W-1:0] q_disp_r;
  logic [DMM_DIM_W-1:0] q_w_r;
  logic [DMM_DIM_W-1:0] q_h_r;

  // Pipeline: memory read, squares, best update.
  dmm_entry_t           rd_data_r;
  logic                 rd_vld_r;
  dmm_entry_t           s2_entry_r;
  logic                 s2_vld_r;
  logic [DMM_SQ_W-1:0]  s2_sqw_r;
  logic [DMM_SQ_W-1:0]  s2_sqh_r;

  // Running bests of the four match rules and of the default search.
  logic                  ex_hit_r;
  logic                  tl_hit_r;
  logic [DMM_DIM_W-1:0]  tl_h_r;
  logic                  sh_hit_r;
  logic [DMM_DIM_W-1:0]  sh_h_r;
  logic                  nr_hit_r;
  logic [DMM_DIM_W-1:0]  nr_w_r;
  logic [DMM_DIM_W-1:0]  nr_h_r;
  logic [DMM_DIST_W-1:0] nr_dist_r;
  logic                  df_hit_r;
  logic [DMM_DIM_W-1:0]  df_w_r;
  logic [DMM_DIM_W-1:0]  df_h_r;

  logic         out_valid_r;
  dmm_out_rsp_t out_rsp_r;
  dmm_out_rsp_t out_rsp_nxt;

  logic                  load_ok;
  logic [DMM_DIM_W-1:0]  dw;
  logic [DMM_DIM_W-1:0]  dh;
  logic [DMM_SQ_W-1:0]   sqw;
  logic [DMM_SQ_W-1:0]   sqh;
  logic [DMM_DIST_W-1:0] dist_sum;
  logic                  e_disp;
  logic                  e_wid;

  assign load_ok = (count_r < CNT_W'(MAX_MODES)) &&
                   ({{(DCMP_W - DMM_DISP_W){1'b0}}, in_req.display} < DCMP_W'(MAX_DISPLAYS));

  assign stat.empty    = (count_r == '0);
  assign stat.last     = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign stat.busy     = rd_vld_r || s2_vld_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  // Table fill count and scan index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.write && load_ok) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.start) begin
        idx_r <= '0;
      end else if (cmd.issue) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && load_ok) begin
      mode_mem_r[count_r[IDX_W-1:0]] <= '{display:    in_req.display,
                                          width:      in_req.width,
                                          height:     in_req.height,
                                          is_default: in_req.is_default};
    end
    if (cmd.issue) begin
      rd_data_r <= mode_mem_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_dflt_r <= (in_req.kind == KIND_DEFAULT);
      q_disp_r <= in_req.display;
      q_w_r    <= in_req.width;
      q_h_r    <= in_req.height;
    end
  end

  // Stage two: squared distances per axis.
  always_comb begin
    dw  = (rd_data_r.width > q_w_r) ? (rd_data_r.width - q_w_r) : (q_w_r - rd_data_r.width);
    dh  = (rd_data_r.height > q_h_r) ? (rd_data_r.height - q_h_r)
                                     : (q_h_r - rd_data_r.height);
    sqw = DMM_SQ_W'(dw) * DMM_SQ_W'(dw);
    sqh = DMM_SQ_W'(dh) * DMM_SQ_W'(dh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      s2_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      s2_entry_r <= rd_data_r;
      s2_sqw_r   <= sqw;
      s2_sqh_r   <= sqh;
    end
  end

  // Stage three: every rule keeps its best so far; strict compares keep the earlier entry.
  assign dist_sum = DMM_DIST_W'(s2_sqw_r) + DMM_DIST_W'(s2_sqh_r);
  assign e_disp   = (s2_entry_r.display == q_disp_r);
  assign e_wid    = (s2_entry_r.width == q_w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_hit_r <= 1'b0;
      tl_hit_r <= 1'b0;
      sh_hit_r <= 1'b0;
      nr_hit_r <= 1'b0;
      df_hit_r <= 1'b0;
    end else if (cmd.start) begin
      ex_hit_r <= 1'b0;
      tl_hit_r <= 1'b0;
      sh_hit_r <= 1'b0;
      nr_hit_r <= 1'b0;
      df_hit_r <= 1'b0;
    end else if (s2_vld_r) begin
      if (q_dflt_r) begin
        if (s2_entry_r.is_default && !df_hit_r) begin
          df_hit_r <= 1'b1;
          df_w_r   <= s2_entry_r.width;
          df_h_r   <= s2_entry_r.height;
        end
      end else if (e_disp) begin
        if (e_wid && (s2_entry_r.height == q_h_r)) begin
          ex_hit_r <= 1'b1;
        end
        if (e_wid && (s2_entry_r.height > q_h_r) &&
            (!tl_hit_r || (s2_entry_r.height < tl_h_r))) begin
          tl_hit_r <= 1'b1;
          tl_h_r   <= s2_entry_r.height;
        end
        if (e_wid && (s2_entry_r.height < q_h_r) &&
            (!sh_hit_r || (s2_entry_r.height > sh_h_r))) begin
          sh_hit_r <= 1'b1;
          sh_h_r   <= s2_entry_r.height;
        end
        if (!nr_hit_r || (dist_sum < nr_dist_r)) begin
          nr_hit_r  <= 1'b1;
          nr_w_r    <= s2_entry_r.width;
          nr_h_r    <= s2_entry_r.height;
          nr_dist_r <= dist_sum;
        end
      end
    end
  end

  // Rule priority: exact, taller, shorter, nearest; default queries stand apart.
  always_comb begin
    out_rsp_nxt = '{out_width: '0, out_height: '0, outcome: OUTC_NONE};
    if (q_dflt_r) begin
      if (df_hit_r) begin
        out_rsp_nxt = '{out_width: df_w_r, out_height: df_h_r, outcome: OUTC_DEFAULT};
      end
    end else if (ex_hit_r) begin
      out_rsp_nxt = '{out_width: q_w_r, out_height: q_h_r, outcome: OUTC_EXACT};
    end else if (tl_hit_r) begin
      out_rsp_nxt = '{out_width: q_w_r, out_height: tl_h_r, outcome: OUTC_TALLER};
    end else if (sh_hit_r) begin
      out_rsp_nxt = '{out_width: q_w_r, out_height: sh_h_r, outcome: OUTC_SHORTER};
    end else if (nr_hit_r) begin
      out_rsp_nxt = '{out_width: nr_w_r, out_height: nr_h_r, outcome: OUTC_NEAREST};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// File: rtl/display_mode_matcher_top.sv
// Top level of the display mode matcher: controller plus datapath.
// Loads and clears give no result. A query reads its N stored modes one per cycle and then
// drains the compare pipeline; its result waits for the output register while an older
// result stalls. The block takes no new request until a query has handed over its result,
// but it takes loads every cycle while idle.
// Reset (rst_n low, synchronous) empties the table and drops any pending result.
`timescale 1ns / 1ps

module display_mode_matcher_top
  import dmm_pkg::*;
#(
  parameter int MAX_MODES    = DMM_MAX_MODES,
  parameter int MAX_DISPLAYS = DMM_MAX_DISPLAYS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  dmm_in_req_t  in_req,
  output logic         out_valid,
  input  logic         out_stall,
  output dmm_out_rsp_t out_rsp
);

  // The controller sees only the request kind and a few status flags; the
  // datapath owns the mode memory, the fill count and the scan index.
  dmm_cmd_t  cmd;
  dmm_stat_t stat;

  // The controller accepts a request only in its idle state. A query then walks
  // the table, waits for the compare pipeline to empty, and hands its result
  // to the output register as soon as that register is free, so a result
  // waiting on a stalled consumer does not block the next request.
  dmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_req.kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath tracks all match rules in parallel during a single pass, so
  // rule priority is resolved only once the whole table has been seen.
  dmm_datapath #(
    .MAX_MODES    (MAX_MODES),
    .MAX_DISPLAYS (MAX_DISPLAYS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

endmodule

// File: rtl/dmm_checker.sv
// Port-level checker for the display mode matcher, bound to its top level.
`timescale 1ns / 1ps

module dmm_checker
  import dmm_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_stall,
  input dmm_in_req_t  in_req,
  input logic         out_valid,
  input logic         out_stall,
  input dmm_out_rsp_t out_rsp
);

  // A held result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  // An empty answer carries zero dimensions.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.outcome == OUTC_NONE) |->
      (out_rsp.out_width == '0) && (out_rsp.out_height == '0))
    else $error("none result with nonzero size");

  // A load or clear does not hold off the request in the cycle after it.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && ((in_req.kind == KIND_LOAD) || (in_req.kind == KIND_CLEAR))
      |=> !in_stall)
    else $error("load or clear blocked the next request");

  // A query holds off new requests while it scans.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && ((in_req.kind == KIND_MATCH) || (in_req.kind == KIND_DEFAULT))
      |=> in_stall)
    else $error("request accepted during a scan");

  // Outcome codes stay within the defined set.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.outcome <= OUTC_NONE))
    else $error("undefined outcome code");

endmodule

bind display_mode_matcher_top dmm_checker u_dmm_checker (.*);

// File: tb/tb_display_mode_matcher_top.sv
// Self-checking testbench for the display mode matcher: directed and random requests.
`timescale 1ns / 1ps

module tb_display_mode_matcher_top;
  import dmm_pkg::*;

  // The run is bounded by a cycle count well above the slowest legal run:
  // about 1700 requests, each worst case a full 64-entry scan, a long sender gap
  // and a long receiver stall, plus the one long hold-off.
  localparam int CYCLE_LIMIT   = 1_200_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 80;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_ITEMS  = 1650;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  dmm_in_req_t  in_req = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  dmm_out_rsp_t out_rsp;

  display_mode_matcher_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  always #4 clk = ~clk;

  // Shadow copy of the mode table, updated as each request is accepted.
  dmm_entry_t   mode_store [DMM_MAX_MODES];
  int           stored_modes = 0;

  // Answers still owed by the block, oldest first.
  dmm_out_rsp_t expected_answers [$];

  int  requests_sent = 0;
  int  answers_seen = 0;
  int  mismatches = 0;
  int  loads_dropped = 0;
  int  outcome_seen [6];
  int  cycle_count = 0;

  // Knobs for the idle behavior of both sides. The sender inserts gaps only
  // while idle_on is set; the receiver stalls with probability stall_pct.
  bit  idle_on = 1'b1;
  int  stall_pct = 20;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;

  // ---------------------------------------------------------------------------
  // Prediction of the mode table and its two kinds of lookup.
  // ---------------------------------------------------------------------------

  function automatic int unsigned sq_gap(input int unsigned a, input int unsigned b);
    int unsigned d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  // A match query: the first rule that finds a mode decides. Exact size first,
  // then the shortest taller and the tallest shorter mode of the same width,
  // and last the mode nearest by squared distance. Ties keep the earlier entry.
  function automatic dmm_out_rsp_t best_mode_for(input logic [DMM_DISP_W-1:0] disp,
                                                 input logic [DMM_DIM_W-1:0] w,
                                                 input logic [DMM_DIM_W-1:0] h);
    dmm_out_rsp_t rsp;
    int           taller;
    int           shorter;
    int           nearest;
    int           pick;
    logic [2:0]   rule;
    int unsigned  gap_sq;
    int unsigned  best_dist;
    rsp.out_width  = '0;
    rsp.out_height = '0;
    rsp.outcome    = OUTC_NONE;
    taller    = -1;
    shorter   = -1;
    nearest   = -1;
    best_dist = 0;
    if (int'(disp) >= DMM_MAX_DISPLAYS) return rsp;
    for (int i = 0; i < stored_modes; i++) begin
      if (mode_store[i].display == disp && mode_store[i].width == w &&
          mode_store[i].height == h) begin
        rsp.out_width  = w;
        rsp.out_height = h;
        rsp.outcome    = OUTC_EXACT;
        return rsp;
      end
    end
    for (int i = 0; i < stored_modes; i++) begin
      if (mode_store[i].display != disp) continue;
      if (mode_store[i].width == w) begin
        if (mode_store[i].height > h &&
            (taller < 0 || mode_store[i].height < mode_store[taller].height))
          taller = i;
        if (mode_store[i].height < h &&
            (shorter < 0 || mode_store[i].height > mode_store[shorter].height))
          shorter = i;
      end
      gap_sq = sq_gap(mode_store[i].width, w) + sq_gap(mode_store[i].height, h);
      if (nearest < 0 || gap_sq < best_dist) begin
        nearest   = i;
        best_dist = gap_sq;
      end
    end
    if (taller >= 0) begin
      pick = taller;
      rule = OUTC_TALLER;
    end else if (shorter >= 0) begin
      pick = shorter;
      rule = OUTC_SHORTER;
    end else if (nearest >= 0) begin
      pick = nearest;
      rule = OUTC_NEAREST;
    end else begin
      return rsp;
    end
    rsp.out_width  = mode_store[pick].width;
    rsp.out_height = mode_store[pick].height;
    rsp.outcome    = rule;
    return rsp;
  endfunction

  // A default query looks at every display and takes the first marked mode.
  function automatic dmm_out_rsp_t first_default_mode();
    dmm_out_rsp_t rsp;
    rsp.out_width  = '0;
    rsp.out_height = '0;
    rsp.outcome    = OUTC_NONE;
    for (int i = 0; i < stored_modes; i++) begin
      if (mode_store[i].is_default) begin
        rsp.out_width  = mode_store[i].width;
        rsp.out_height = mode_store[i].height;
        rsp.outcome    = OUTC_DEFAULT;
        return rsp;
      end
    end
    return rsp;
  endfunction

  // Applies one accepted request to the shadow table and queues its answer.
  function automatic void absorb_request(input dmm_in_req_t req);
    case (req.kind)
      KIND_LOAD: begin
        if (stored_modes < DMM_MAX_MODES && int'(req.display) < DMM_MAX_DISPLAYS) begin
          mode_store[stored_modes].display    = req.display;
          mode_store[stored_modes].width      = req.width;
          mode_store[stored_modes].height     = req.height;
          mode_store[stored_modes].is_default = req.is_default;
          stored_modes++;
        end else begin
          loads_dropped++;
        end
      end
      KIND_CLEAR: begin
        stored_modes = 0;
      end
      KIND_MATCH: begin
        expected_answers.insert(expected_answers.size(),
                                best_mode_for(req.display, req.width, req.height));
      end
      default: begin
        expected_answers.insert(expected_answers.size(), first_default_mode());
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  // Gaps between requests: mostly none, often short, now and then long.
  function automatic int next_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic dmm_in_req_t make_request(input dmm_kind_t kind, input int disp,
                                               input int w, input int h, input bit dflt);
    dmm_in_req_t req;
    req.kind       = kind;
    req.display    = DMM_DISP_W'(disp);
    req.width      = DMM_DIM_W'(w);
    req.height     = DMM_DIM_W'(h);
    req.is_default = dflt;
    return req;
  endfunction

  // Fields a request does not use are filled with noise, since the block
  // has to ignore them.
  function automatic dmm_in_req_t noisy_request(input dmm_kind_t kind);
    return make_request(kind, $urandom_range(0, 3), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 1));
  endfunction

  // Offers one request and holds it until the block takes it. The valid is
  // only lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_request(input dmm_in_req_t req);
    int gap;
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_request(req);
    requests_sent++;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Answer side: stall pattern, the long hold-off, and the checker.
  // ---------------------------------------------------------------------------

  // The receiver stalls in runs. Most runs are short, a few are long, and a
  // hold-off request freezes the output until the hold counter, loaded from HOLD_CYCLES, runs out.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) - 1
                                                : $urandom_range(1, 3) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic log_mismatch(input string what, input dmm_out_rsp_t want,
                              input dmm_out_rsp_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("Mismatch (%s) at cycle %0d: expected %0dx%0d outcome %0d, got %0dx%0d outcome %0d",
               what, cycle_count, want.out_width, want.out_height, want.outcome,
               got.out_width, got.out_height, got.outcome);
  endtask

  // Every answer taken by the handshake is held against the oldest one owed.
  always @(posedge clk) begin
    dmm_out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      answers_seen++;
      if (out_rsp.outcome <= OUTC_NONE) outcome_seen[out_rsp.outcome]++;
      if (expected_answers.size() == 0) begin
        want = '0;
        log_mismatch("answer with no query pending", want, out_rsp);
      end else begin
        want = expected_answers.pop_front();
        if (out_rsp.out_width !== want.out_width)
          log_mismatch("width", want, out_rsp);
        else if (out_rsp.out_height !== want.out_height)
          log_mismatch("height", want, out_rsp);
        else if (out_rsp.outcome !== want.outcome)
          log_mismatch("outcome", want, out_rsp);
      end
    end
  end

  // A hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d answers outstanding.",
               cycle_count, expected_answers.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Both kinds of query on a table that has never held a mode must say none.
  task automatic test_empty_table();
    send_request(make_request(KIND_MATCH, 0, 640, 480, 1'b0));
    send_request(noisy_request(KIND_DEFAULT));
  endtask

  // A small hand-built table that reaches each lookup rule, the field extremes,
  // the tie to the earlier entry, and a display with no modes of its own.
  task automatic test_lookup_rules();
    send_request(noisy_request(KIND_CLEAR));
    send_request(make_request(KIND_LOAD, 0, 640, 480, 1'b0));
    send_request(make_request(KIND_LOAD, 0, 640, 400, 1'b0));
    send_request(make_request(KIND_LOAD, 0, 640, 720, 1'b0));
    send_request(make_request(KIND_LOAD, 0, 640, 600, 1'b0));
    send_request(make_request(KIND_LOAD, 1, 4095, 4095, 1'b1));
    send_request(make_request(KIND_LOAD, 2, 0, 0, 1'b0));
    send_request(make_request(KIND_LOAD, 0, 800, 480, 1'b1));
    // Exact, then shortest taller, then tallest shorter on width 640.
    send_request(make_request(KIND_MATCH, 0, 640, 480, 1'b1));
    send_request(make_request(KIND_MATCH, 0, 640, 500, 1'b0));
    send_request(make_request(KIND_MATCH, 0, 640, 4095, 1'b0));
    send_request(make_request(KIND_MATCH, 0, 640, 0, 1'b0));
    // 720x480 lies equally far from 640x480 and 800x480: the earlier one wins.
    send_request(make_request(KIND_MATCH, 0, 720, 480, 1'b0));
    // Corner to corner: the largest possible distance still picks the mode.
    send_request(make_request(KIND_MATCH, 1, 0, 0, 1'b0));
    send_request(make_request(KIND_MATCH, 2, 4095, 4095, 1'b0));
    // Display 3 has no modes, so nothing is found.
    send_request(make_request(KIND_MATCH, 3, 640, 480, 1'b0));
    send_request(noisy_request(KIND_DEFAULT));
    // After a clear the table is empty again, whatever the clear carried.
    send_request(make_request(KIND_CLEAR, 3, 4095, 4095, 1'b1));
    send_request(make_request(KIND_MATCH, 0, 640, 480, 1'b0));
    send_request(noisy_request(KIND_DEFAULT));
    send_request(make_request(KIND_LOAD, 3, 1920, 1080, 1'b0));
    send_request(make_request(KIND_MATCH, 0, 1920, 1080, 1'b0));
    send_request(make_request(KIND_MATCH, 3, 1920, 1080, 1'b0));
  endtask

  // The receiver holds off for a long stretch while queries keep coming with
  // no gaps, so the output fills and the block has to stall its input.
  task automatic test_output_hold();
    bit saved_idle;
    saved_idle = idle_on;
    idle_on = 1'b0;
    send_request(noisy_request(KIND_CLEAR));
    repeat (6) send_request(make_request(KIND_LOAD, $urandom_range(0, 3),
                                         $urandom_range(0, 4095), $urandom_range(0, 4095),
                                         $urandom_range(0, 1)));
    hold_request = 1'b1;
    repeat (20) send_request(make_request(KIND_MATCH, $urandom_range(0, 3),
                                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                                          1'b0));
    idle_on = saved_idle;
  endtask

  // Random sessions until the request count reaches the target. A session
  // clears the table, loads modes that share a few widths so that the
  // same-width rules fire, then asks queries aimed at what was loaded. Some
  // sessions overfill the table, some skip the clear, and a few requests are
  // plain noise of any kind.
  task automatic test_random_sessions(input int target);
    int                   n_loads;
    int                   n_queries;
    int                   roll;
    int                   idx;
    int                   h;
    logic [DMM_DIM_W-1:0] wpool [4];
    while (requests_sent < target) begin
      roll = $urandom_range(0, 19);
      n_loads   = (roll == 0) ? $urandom_range(60, 72) : $urandom_range(1, 12);
      n_queries = $urandom_range(3, 12);
      foreach (wpool[k]) wpool[k] = $urandom_range(0, 4095);
      if (roll != 1) send_request(noisy_request(KIND_CLEAR));
      repeat (n_loads) begin
        send_request(make_request(KIND_LOAD, $urandom_range(0, 3),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                              : wpool[$urandom_range(0, 3)],
                                  $urandom_range(0, 4095), $urandom_range(0, 7) == 0));
      end
      repeat (n_queries) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          send_request(noisy_request(dmm_kind_t'($urandom_range(0, 3))));
        end else if (roll < 20) begin
          send_request(noisy_request(KIND_DEFAULT));
        end else if (roll < 45 && stored_modes > 0) begin
          idx = $urandom_range(0, stored_modes - 1);
          send_request(make_request(KIND_MATCH, mode_store[idx].display,
                                    mode_store[idx].width, mode_store[idx].height,
                                    $urandom_range(0, 1)));
        end else if (roll < 70 && stored_modes > 0) begin
          // Same width as a stored mode, height near it or anywhere.
          idx = $urandom_range(0, stored_modes - 1);
          h = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                          : int'(mode_store[idx].height) +
                                            $urandom_range(0, 64) - 32;
          if (h < 0) h = 0;
          if (h > 4095) h = 4095;
          send_request(make_request(KIND_MATCH, mode_store[idx].display,
                                    mode_store[idx].width, h, $urandom_range(0, 1)));
        end else begin
          send_request(make_request(KIND_MATCH, $urandom_range(0, 3),
                                    ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                                                : wpool[$urandom_range(0, 3)],
                                    $urandom_range(0, 4095), $urandom_range(0, 1)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------

  initial begin
    // Reset is held low at the start and released once before the first request
    // is offered.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_lookup_rules();
    test_output_hold();

    // A stretch with no idling on either side.
    idle_on   = 1'b0;
    stall_pct = 0;
    test_random_sessions(requests_sent + 200);

    // The bulk of the random requests with moderate, then heavy, stalling.
    idle_on   = 1'b1;
    stall_pct = 20;
    test_random_sessions(requests_sent + RANDOM_ITEMS - 650);
    stall_pct = 60;
    test_random_sessions(requests_sent + 450);

    in_valid <= 1'b0;

    // Wait for every owed answer, then a little longer to catch strays.
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d answers: exact %0d, taller %0d, shorter %0d,",
             requests_sent, answers_seen, outcome_seen[OUTC_EXACT],
             outcome_seen[OUTC_TALLER], outcome_seen[OUTC_SHORTER]);
    $display("nearest %0d, default %0d, none %0d; %0d loads refused by a full table.",
             outcome_seen[OUTC_NEAREST], outcome_seen[OUTC_DEFAULT],
             outcome_seen[OUTC_NONE], loads_dropped);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
